>>> rtl/core/cmm_pkg.sv
// shared widths, codes and defaults for the cluster membership block
`default_nettype none

package cmm_pkg;

	localparam int NUM_RECORDS_DEF = 64;

	localparam int ID_W     = 6;
	localparam int SIZE_W   = 7;
	localparam int MEMBER_W = 7;

	typedef enum logic {
		OP_MOVE = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic {
		ST_OK        = 1'b0,
		ST_NOT_FOUND = 1'b1
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/cmm_if.sv
// request and response channel interfaces for the cluster membership block
`default_nettype none

interface cmm_req_if import cmm_pkg::*; ();
	logic            valid;
	logic            ready;
	op_t             opcode;
	logic [ID_W-1:0] record_index;
	logic [ID_W-1:0] from_cluster;
	logic [ID_W-1:0] to_cluster;
	logic [ID_W-1:0] slot_index;

	modport source (
		output valid, opcode, record_index, from_cluster, to_cluster, slot_index,
		input  ready
	);
	modport sink (
		input  valid, opcode, record_index, from_cluster, to_cluster, slot_index,
		output ready
	);
endinterface

interface cmm_rsp_if import cmm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [SIZE_W-1:0]          from_size;
	logic [SIZE_W-1:0]          to_size;
	logic [SIZE_W-1:0]          nonempty_count;
	logic signed [MEMBER_W-1:0] member_value;
	status_t                    status;

	modport source (
		output valid, from_size, to_size, nonempty_count, member_value, status,
		input  ready
	);
	modport sink (
		input  valid, from_size, to_size, nonempty_count, member_value, status,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/cluster_membership_move.sv
// cluster membership store with record move and member read
// move: reads both cluster sizes, then scans the member row of the source cluster for the record,
//   at one member memory read and at most one write per cycle, and moves it to the target cluster
// read: reads the cluster sizes, then the member memory entry at the slot index
// a result waits in the output register while the next beat runs
// after reset a fill pass seeds every record alone in its own cluster; no beat is taken until then
`default_nettype none

module cluster_membership_move import cmm_pkg::*; #(
	parameter int NUM_RECORDS = NUM_RECORDS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	cmm_req_if.sink       req,
	cmm_rsp_if.source     rsp
);

	localparam int RW    = $clog2(NUM_RECORDS);
	localparam int SW    = $clog2(NUM_RECORDS + 1);
	localparam int DEPTH = NUM_RECORDS * NUM_RECORDS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = (RW > ID_W) ? RW : ID_W;
	localparam int CW    = XW + 1;

	typedef enum logic [10:0] {
		S_INIT   = 11'b000_0000_0001,
		S_IDLE   = 11'b000_0000_0010,
		S_SZA    = 11'b000_0000_0100,
		S_SZB    = 11'b000_0000_1000,
		S_SZC    = 11'b000_0001_0000,
		S_DECIDE = 11'b000_0010_0000,
		S_SCAN   = 11'b000_0100_0000,
		S_APPEND = 11'b000_1000_0000,
		S_SZWR   = 11'b001_0000_0000,
		S_RDMEM  = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [RW-1:0] member_mem [DEPTH];
	logic [SW-1:0] size_mem [NUM_RECORDS];

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [RW-1:0] mem_wd;
	logic [AW-1:0] mem_ra;
	logic [RW-1:0] mem_rd_q;

	logic          sz_we;
	logic [RW-1:0] sz_wa;
	logic [SW-1:0] sz_wd;
	logic [RW-1:0] sz_ra;
	logic [SW-1:0] sz_rd_q;

	logic [RW-1:0] init_cnt_q;
	logic [AW-1:0] init_base_q;
	logic [SW-1:0] cnt_q;
	logic          out_valid_q;

	op_t            op_q;
	logic [ID_W-1:0] r_q, a_q, b_q, s_q;
	logic [SW-1:0]  size_a_q, size_b_q;
	logic [SW-1:0]  rk_q, dk_q;
	logic           dv_q;
	logic           found_q;
	status_t        status_q;
	logic [MEMBER_W-1:0] member_q;

	logic [SIZE_W-1:0]   from_size_q, to_size_q, nonempty_q;
	logic [MEMBER_W-1:0] member_out_q;
	status_t             status_out_q;

	logic          r_ok, a_ok, b_ok, s_ok;
	logic [AW-1:0] base_a, base_b;
	logic          scan_end;
	logic          out_load;
	logic          dec_cnt, inc_cnt;

	assign r_ok = CW'(r_q) < CW'(NUM_RECORDS);
	assign a_ok = CW'(a_q) < CW'(NUM_RECORDS);
	assign b_ok = CW'(b_q) < CW'(NUM_RECORDS);
	assign s_ok = CW'(s_q) < CW'(NUM_RECORDS);

	assign base_a = AW'(AW'(RW'(a_q)) * AW'(NUM_RECORDS));
	assign base_b = AW'(AW'(RW'(b_q)) * AW'(NUM_RECORDS));

	assign scan_end = (rk_q == size_a_q) && !dv_q;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign dec_cnt  = (size_a_q == '0) && (cnt_q != '0);
	assign inc_cnt  = (size_b_q == '0);

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.from_size      = from_size_q;
	assign rsp.to_size        = to_size_q;
	assign rsp.nonempty_count = nonempty_q;
	assign rsp.member_value   = member_out_q;
	assign rsp.status         = status_out_q;

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = '0;
		sz_we  = 1'b0;
		sz_wa  = '0;
		sz_wd  = '0;
		sz_ra  = '0;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wa = init_base_q;
				mem_wd = init_cnt_q;
				sz_we  = 1'b1;
				sz_wa  = init_cnt_q;
				sz_wd  = SW'(1);
			end
			S_SZA: begin
				sz_ra = RW'(a_q);
			end
			S_SZB: begin
				sz_ra = RW'(b_q);
			end
			S_DECIDE: begin
				mem_ra = base_a + AW'(s_q);
			end
			S_SCAN: begin
				mem_ra = base_a + AW'(rk_q);
				if (dv_q && found_q) begin
					mem_we = 1'b1;
					mem_wa = base_a + AW'(dk_q - SW'(1));
					mem_wd = mem_rd_q;
				end
			end
			S_APPEND: begin
				mem_we = 1'b1;
				mem_wa = base_b + AW'(size_b_q);
				mem_wd = RW'(r_q);
				sz_we  = 1'b1;
				sz_wa  = RW'(a_q);
				sz_wd  = size_a_q - SW'(1);
			end
			S_SZWR: begin
				sz_we = 1'b1;
				sz_wa = RW'(b_q);
				sz_wd = size_b_q + SW'(1);
			end
			S_IDLE, S_SZC, S_RDMEM, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) member_mem[mem_wa] <= mem_wd;
		mem_rd_q <= member_mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (sz_we) size_mem[sz_wa] <= sz_wd;
		sz_rd_q <= size_mem[sz_ra];
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_cnt_q  <= '0;
			init_base_q <= '0;
			cnt_q       <= SW'(NUM_RECORDS);
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_INIT: begin
					init_cnt_q  <= init_cnt_q + RW'(1);
					init_base_q <= init_base_q + AW'(NUM_RECORDS);
					if (init_cnt_q == RW'(NUM_RECORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) state_q <= S_SZA;
				end
				S_SZA:  state_q <= S_SZB;
				S_SZB:  state_q <= S_SZC;
				S_SZC:  state_q <= S_DECIDE;
				S_DECIDE: begin
					priority if (op_q == OP_READ) state_q <= S_RDMEM;
					else if (!(r_ok && a_ok && b_ok) || (a_q == b_q)
						|| (size_b_q == SW'(NUM_RECORDS))) state_q <= S_DONE;
					else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_end) state_q <= found_q ? S_APPEND : S_DONE;
				end
				S_APPEND: state_q <= S_SZWR;
				S_SZWR: begin
					if (dec_cnt && !inc_cnt) cnt_q <= cnt_q - SW'(1);
					else if (inc_cnt && !dec_cnt) cnt_q <= cnt_q + SW'(1);
					state_q <= S_DONE;
				end
				S_RDMEM: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= req.opcode;
				r_q      <= req.record_index;
				a_q      <= req.from_cluster;
				b_q      <= req.to_cluster;
				s_q      <= req.slot_index;
				member_q <= '0;
				status_q <= ST_OK;
			end
			S_SZB: begin
				size_a_q <= a_ok ? sz_rd_q : '0;
			end
			S_SZC: begin
				size_b_q <= b_ok ? sz_rd_q : '0;
			end
			S_DECIDE: begin
				rk_q    <= '0;
				dk_q    <= '0;
				dv_q    <= 1'b0;
				found_q <= 1'b0;
				if (op_q == OP_MOVE) begin
					if (!(r_ok && a_ok && b_ok)) status_q <= ST_NOT_FOUND;
					else if ((a_q != b_q) && (size_b_q == SW'(NUM_RECORDS)))
						status_q <= ST_NOT_FOUND;
				end
			end
			S_SCAN: begin
				if (rk_q < size_a_q) begin
					rk_q <= rk_q + SW'(1);
					dk_q <= rk_q;
					dv_q <= 1'b1;
				end else begin
					dv_q <= 1'b0;
				end
				if (dv_q && !found_q && (XW'(mem_rd_q) == XW'(r_q))) found_q <= 1'b1;
				if (scan_end && !found_q) status_q <= ST_NOT_FOUND;
			end
			S_APPEND: begin
				size_a_q <= size_a_q - SW'(1);
			end
			S_SZWR: begin
				size_b_q <= size_b_q + SW'(1);
			end
			S_RDMEM: begin
				if (a_ok && s_ok && (CW'(s_q) < CW'(size_a_q)))
					member_q <= MEMBER_W'(mem_rd_q);
				else
					member_q <= '1;
			end
			S_INIT, S_SZA, S_DONE: begin
			end
			default: begin
			end
		endcase

		if (out_load) begin
			from_size_q  <= SIZE_W'(size_a_q);
			to_size_q    <= SIZE_W'(size_b_q);
			nonempty_q   <= SIZE_W'(cnt_q);
			member_out_q <= member_q;
			status_out_q <= status_q;
		end
	end

endmodule

`default_nettype wire
